/* hw/rtl/b58ks_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b58ks_pkg
// Shared types, constants and helpers of the base58 key scanner.
// ----------------------------------------------------------------------------
package b58ks_pkg;

  localparam int DEF_MAX_KEY_LENGTH    = 64;
  localparam int DEF_MIN_KEY_LENGTH    = 32;
  localparam int DEF_MAX_PREFIX_LENGTH = 16;

  localparam int PREFIX_LENGTH_W = 5;
  localparam int PREFIX_WORD_W   = 64;
  localparam int STATUS_W        = 2;
  localparam int KEY_BYTE_W      = 8;
  localparam int KEY_LENGTH_W    = 7;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = 24;
  localparam int CFG_INDEX_W     = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_KEY      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CONFLICT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_LENGTH      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_FIRST_EIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_LAST_EIGHT  = 2'd2;

  typedef enum logic {
    ST_SCAN,
    ST_EMIT
  } b58ks_state_t;

  typedef struct packed {
    logic [PREFIX_LENGTH_W-1:0] prefix_length;
    logic [PREFIX_WORD_W-1:0]   prefix_first_eight;
    logic [PREFIX_WORD_W-1:0]   prefix_last_eight;
  } b58ks_cfg_t;

  // Base58 alphabet: digits 1-9, letters without I, O and l.
  function automatic logic in_alphabet(input logic [7:0] b);
    logic ok;
    ok = 1'b0;
    if (b >= 8'h31 && b <= 8'h39) ok = 1'b1;
    if (b >= 8'h41 && b <= 8'h5a) ok = (b != 8'h49) && (b != 8'h4f);
    if (b >= 8'h61 && b <= 8'h7a) ok = (b != 8'h6c);
    return ok;
  endfunction

endpackage

/* hw/rtl/base58_key_scanner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base58_key_scanner_top
// Finds a unique prefixed base58 key in a byte stream and reports it.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock while it is scanning; the key store
// is read every cycle at the next run position, so checking a byte against
// a stored key never stalls. After the byte flagged with in_tlast the input
// is held off while the answer goes out: one transaction for no key, an
// empty prefix or a conflict, otherwise one transaction per stored key
// character, walking the key store one entry per cycle while the output is
// not stalled. Input is taken again as soon as the last answer
// transaction sits in the output register.
module base58_key_scanner_top #(
  parameter int MAX_KEY_LENGTH    = b58ks_pkg::DEF_MAX_KEY_LENGTH,
  parameter int MIN_KEY_LENGTH    = b58ks_pkg::DEF_MIN_KEY_LENGTH,
  parameter int MAX_PREFIX_LENGTH = b58ks_pkg::DEF_MAX_PREFIX_LENGTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [b58ks_pkg::IN_TDATA_W-1:0]     in_tdata,   // data_byte
  input  logic                                 in_tlast,   // last_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [b58ks_pkg::OUT_TDATA_W-1:0]    out_tdata,  // status, key_byte, key_length, zero pad
  output logic                                 out_tlast,  // last_result
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [b58ks_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [b58ks_pkg::PREFIX_WORD_W-1:0]  cfg_data
);

  import b58ks_pkg::*;

  b58ks_cfg_t cfg_r, cfg_nxt;

  logic [STATUS_W-1:0]     out_status;
  logic [KEY_BYTE_W-1:0]   out_key_byte;
  logic [KEY_LENGTH_W-1:0] out_key_length;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PREFIX_LENGTH:      cfg_nxt.prefix_length = cfg_data[PREFIX_LENGTH_W-1:0];
        REG_PREFIX_FIRST_EIGHT: cfg_nxt.prefix_first_eight = cfg_data;
        REG_PREFIX_LAST_EIGHT:  cfg_nxt.prefix_last_eight = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  b58ks_core #(
    .MAX_KEY_LENGTH    (MAX_KEY_LENGTH),
    .MIN_KEY_LENGTH    (MIN_KEY_LENGTH),
    .MAX_PREFIX_LENGTH (MAX_PREFIX_LENGTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_byte        (in_tdata[7:0]),
    .in_last        (in_tlast),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_status     (out_status),
    .out_key_byte   (out_key_byte),
    .out_key_length (out_key_length),
    .out_last       (out_tlast)
  );

  assign out_tdata = {(OUT_TDATA_W - STATUS_W - KEY_BYTE_W - KEY_LENGTH_W)'(0),
                      out_key_length, out_key_byte, out_status};

`ifndef SYNTH
  // Anything but a key character is a lone, final transaction with no payload.
  a_nokey_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_status != STATUS_KEY |-> out_tlast && out_key_byte == '0 &&
      out_key_length == '0)
    else $error("non-key result carries payload or is not final");

  // The byte that ends a buffer hands control to the answer sequencer.
  a_last_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted right after the final byte");

  // A key character never reports an empty key.
  a_key_length_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_status == STATUS_KEY |-> out_key_length != '0)
    else $error("key character with zero key length");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_status == STATUS_NONE || out_status == STATUS_KEY ||
      out_status == STATUS_CONFLICT)
    else $error("undefined status code");
`endif

endmodule

/* hw/rtl/b58ks_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b58ks_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module b58ks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

/* hw/rtl/b58ks_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b58ks_core
// Run tracker, key store and answer sequencer of the base58 key scanner.
// ----------------------------------------------------------------------------
module b58ks_core #(
  parameter int MAX_KEY_LENGTH    = b58ks_pkg::DEF_MAX_KEY_LENGTH,
  parameter int MIN_KEY_LENGTH    = b58ks_pkg::DEF_MIN_KEY_LENGTH,
  parameter int MAX_PREFIX_LENGTH = b58ks_pkg::DEF_MAX_PREFIX_LENGTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  b58ks_pkg::b58ks_cfg_t               cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_byte,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [b58ks_pkg::STATUS_W-1:0]      out_status,
  output logic [b58ks_pkg::KEY_BYTE_W-1:0]    out_key_byte,
  output logic [b58ks_pkg::KEY_LENGTH_W-1:0]  out_key_length,
  output logic                                out_last
);

  import b58ks_pkg::*;

  localparam int ADDR_W = $clog2(MAX_KEY_LENGTH);
  localparam int LEN_W  = $clog2(MAX_KEY_LENGTH + 2);
  localparam int CW     = (LEN_W > 7) ? LEN_W : 7;

  b58ks_state_t state_r, state_nxt;

  logic [LEN_W-1:0] run_count_r, run_count_nxt;
  logic             prefix_ok_r, prefix_ok_nxt;
  logic             equal_r, equal_nxt;
  logic             key_present_r, key_present_nxt;
  logic             conflict_r, conflict_nxt;
  logic [LEN_W-1:0] key_len_r, key_len_nxt;
  logic [LEN_W-1:0] emit_idx_r, emit_idx_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [KEY_BYTE_W-1:0]   out_key_byte_r, out_key_byte_nxt;
  logic [KEY_LENGTH_W-1:0] out_key_length_r, out_key_length_nxt;
  logic                    out_last_r, out_last_nxt;

  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [7:0]        mem_rd_data;
  logic              fwd_hit_r, fwd_hit_nxt;
  logic [7:0]        fwd_byte_r;
  logic [7:0]        store_q;

  logic                       accept;
  logic                       is_alpha;
  logic [PREFIX_LENGTH_W-1:0] plen;
  logic [CW-1:0]              rc_ext, plen_ext, t_rc_ext;
  logic [15:0][7:0]           pfx;
  logic [LEN_W-1:0]           t_rc;
  logic                       t_pm, t_eq;
  logic                       judge_now, judge_ok;
  logic                       slot_free, emit_single, emit_final;

  assign in_ready  = (state_r == ST_SCAN);
  assign accept    = in_valid && in_ready;
  assign is_alpha  = in_alphabet(in_byte);
  assign plen      = (cfg.prefix_length > PREFIX_LENGTH_W'(MAX_PREFIX_LENGTH)) ?
                     PREFIX_LENGTH_W'(MAX_PREFIX_LENGTH) : cfg.prefix_length;
  assign plen_ext  = CW'(plen);
  assign rc_ext    = CW'(run_count_r);
  assign pfx       = {cfg.prefix_last_eight, cfg.prefix_first_eight};
  assign slot_free = !out_valid_r || out_ready;

  assign emit_single = (cfg.prefix_length == '0) || conflict_r || !key_present_r;
  assign emit_final  = emit_single || ((emit_idx_r + LEN_W'(1)) == key_len_r);

  // The store returns the old contents when an entry is written and read in
  // the same cycle, so that byte is forwarded from a side register.
  assign store_q = fwd_hit_r ? fwd_byte_r : mem_rd_data;

  // While scanning, the store is read every cycle at the position the run will
  // have next, so the stored byte for comparison is ready when the next byte arrives.
  always_comb begin
    t_rc      = run_count_r;
    t_pm      = prefix_ok_r;
    t_eq      = equal_r;
    mem_wr_en = 1'b0;
    if (is_alpha) begin
      if (rc_ext < plen_ext && in_byte != pfx[rc_ext[3:0]]) begin
        t_pm = 1'b0;
      end
      if (rc_ext < CW'(MAX_KEY_LENGTH)) begin
        if (!key_present_r) begin
          mem_wr_en = accept;
        end else if (rc_ext >= CW'(key_len_r) || store_q != in_byte) begin
          t_eq = 1'b0;
        end
      end else begin
        t_eq = 1'b0;
      end
      if (rc_ext <= CW'(MAX_KEY_LENGTH)) begin
        t_rc = run_count_r + LEN_W'(1);
      end
    end
  end

  assign t_rc_ext  = CW'(t_rc);
  assign judge_now = accept && (!is_alpha || in_last) && (t_rc != '0);
  assign judge_ok  = (t_rc_ext >= CW'(MIN_KEY_LENGTH)) &&
                     (t_rc_ext <= CW'(MAX_KEY_LENGTH)) &&
                     (t_rc_ext >= plen_ext) && (plen != '0) &&
                     t_pm && !conflict_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SCAN: begin
        if (accept && in_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && emit_final) state_nxt = ST_SCAN;
      end
      default: state_nxt = ST_SCAN;
    endcase
  end

  always_comb begin
    run_count_nxt      = run_count_r;
    prefix_ok_nxt      = prefix_ok_r;
    equal_nxt          = equal_r;
    key_present_nxt    = key_present_r;
    conflict_nxt       = conflict_r;
    key_len_nxt        = key_len_r;
    emit_idx_nxt       = emit_idx_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_status_nxt     = out_status_r;
    out_key_byte_nxt   = out_key_byte_r;
    out_key_length_nxt = out_key_length_r;
    out_last_nxt       = out_last_r;
    unique case (state_r)
      ST_SCAN: begin
        emit_idx_nxt = '0;
        if (accept) begin
          if (judge_now) begin
            run_count_nxt = '0;
            prefix_ok_nxt = 1'b1;
            equal_nxt     = 1'b1;
            if (judge_ok) begin
              if (!key_present_r) begin
                key_present_nxt = 1'b1;
                key_len_nxt     = t_rc;
              end else if (!(t_eq && t_rc == key_len_r)) begin
                conflict_nxt = 1'b1;
              end
            end
          end else begin
            run_count_nxt = t_rc;
            prefix_ok_nxt = t_pm;
            equal_nxt     = t_eq;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = emit_final;
          if (emit_single) begin
            out_status_nxt     = (cfg.prefix_length != '0 && conflict_r) ?
                                 STATUS_CONFLICT : STATUS_NONE;
            out_key_byte_nxt   = '0;
            out_key_length_nxt = '0;
          end else begin
            out_status_nxt     = STATUS_KEY;
            out_key_byte_nxt   = store_q;
            out_key_length_nxt = KEY_LENGTH_W'(key_len_r);
            emit_idx_nxt       = emit_idx_r + LEN_W'(1);
          end
          if (emit_final) begin
            key_present_nxt = 1'b0;
            conflict_nxt    = 1'b0;
            key_len_nxt     = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign mem_rd_addr = (state_r == ST_EMIT) ? emit_idx_nxt[ADDR_W-1:0] :
                                              run_count_nxt[ADDR_W-1:0];

  assign fwd_hit_nxt = mem_wr_en && (run_count_r[ADDR_W-1:0] == mem_rd_addr);

  b58ks_ram #(
    .WIDTH (8),
    .DEPTH (MAX_KEY_LENGTH)
  ) u_key_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (run_count_r[ADDR_W-1:0]),
    .wr_data (in_byte),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SCAN;
      run_count_r   <= '0;
      prefix_ok_r   <= 1'b1;
      equal_r       <= 1'b1;
      key_present_r <= 1'b0;
      conflict_r    <= 1'b0;
      key_len_r     <= '0;
      emit_idx_r    <= '0;
      out_valid_r   <= 1'b0;
      fwd_hit_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      run_count_r   <= run_count_nxt;
      prefix_ok_r   <= prefix_ok_nxt;
      equal_r       <= equal_nxt;
      key_present_r <= key_present_nxt;
      conflict_r    <= conflict_nxt;
      key_len_r     <= key_len_nxt;
      emit_idx_r    <= emit_idx_nxt;
      out_valid_r   <= out_valid_nxt;
      fwd_hit_r     <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r     <= out_status_nxt;
    out_key_byte_r   <= out_key_byte_nxt;
    out_key_length_r <= out_key_length_nxt;
    out_last_r       <= out_last_nxt;
    fwd_byte_r       <= in_byte;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_key_byte   = out_key_byte_r;
  assign out_key_length = out_key_length_r;
  assign out_last       = out_last_r;

endmodule

/* sim/tb_base58_key_scanner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base58_key_scanner_top
// Self-checking testbench for the base58 key scanner.
// ----------------------------------------------------------------------------
// Byte buffers are streamed into the scanner while a cycle-level predictor
// tracks base58 runs, the prefix match and the stored key. Every result
// transaction is compared field by field against the oldest predicted one.
// Directed buffers cover an empty prefix, run length limits, open runs at
// the last byte, conflicts and full or oversized prefixes, each under its
// own input and output pressure mode.
module tb_base58_key_scanner_top;
  import b58ks_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int KEY_MAX       = DEF_MAX_KEY_LENGTH;
  localparam int KEY_MIN       = DEF_MIN_KEY_LENGTH;
  localparam int PFX_MAX       = DEF_MAX_PREFIX_LENGTH;
  localparam int DRAIN_CYCLES  = 8;
  localparam int LIMIT_NS      = 12_000_000;
  localparam int KB_LSB        = STATUS_W;
  localparam int KL_LSB        = STATUS_W + KEY_BYTE_W;
  localparam int PAD_LSB       = KL_LSB + KEY_LENGTH_W;
  localparam logic [58*8-1:0] B58_CHARS =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [KEY_BYTE_W-1:0]   key_byte;
    logic [KEY_LENGTH_W-1:0] key_length;
    logic                    is_last;
  } answer_beat_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    in_tlast = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = REG_PREFIX_LENGTH;
  logic [PREFIX_WORD_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the scan state.
  logic [PREFIX_LENGTH_W-1:0] pfx_len_reg = '0;
  logic [PREFIX_WORD_W-1:0]   pfx_lo_reg = '0;
  logic [PREFIX_WORD_W-1:0]   pfx_hi_reg = '0;
  logic [7:0] key_mem [KEY_MAX];
  int  key_len = 0;
  bit  key_found = 1'b0;
  bit  conflict = 1'b0;
  int  run_len = 0;
  bit  run_pfx_ok = 1'b1;
  bit  run_same = 1'b1;

  answer_beat_t answer_q[$];
  logic [7:0]   run_buf[$];
  logic [7:0]   saved_run[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int bytes_sent = 0;
  int buffers_sent = 0;
  int beats_checked = 0;

  base58_key_scanner_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic bit is_b58(logic [7:0] b);
    for (int i = 0; i < 58; i++) begin
      if (B58_CHARS[8*i +: 8] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int eff_pfx_len();
    return (pfx_len_reg > PFX_MAX) ? PFX_MAX : int'(pfx_len_reg);
  endfunction

  function automatic logic [7:0] pfx_char(int p);
    if (p < 8) return pfx_lo_reg[8*p +: 8];
    return pfx_hi_reg[8*(p-8) +: 8];
  endfunction

  function automatic void restart_run();
    run_len = 0;
    run_pfx_ok = 1'b1;
    run_same = 1'b1;
  endfunction

  function automatic void judge_run();
    int plen;
    plen = eff_pfx_len();
    if (run_len >= KEY_MIN && run_len <= KEY_MAX && run_len >= plen && plen != 0 &&
        run_pfx_ok && !conflict) begin
      if (!key_found) begin
        key_found = 1'b1;
        key_len = run_len;
      end else if (!(run_same && run_len == key_len)) begin
        conflict = 1'b1;
      end
    end
    restart_run();
  endfunction

  function automatic void extend_run(logic [7:0] b);
    int plen;
    plen = eff_pfx_len();
    if (run_len < plen && b != pfx_char(run_len)) run_pfx_ok = 1'b0;
    if (run_len < KEY_MAX) begin
      if (!key_found) key_mem[run_len] = b;
      else if (run_len >= key_len || key_mem[run_len] != b) run_same = 1'b0;
    end else begin
      run_same = 1'b0;
    end
    // The run counter saturates one past the longest key.
    if (run_len <= KEY_MAX) run_len++;
  endfunction

  function automatic void predict_answer(logic [7:0] b, logic last);
    answer_beat_t beat;
    if (is_b58(b)) extend_run(b);
    else if (run_len != 0) judge_run();
    if (!last) return;
    if (run_len != 0) judge_run();
    if (pfx_len_reg == 0 || conflict || !key_found) begin
      beat.status     = (pfx_len_reg != 0 && conflict) ? STATUS_CONFLICT : STATUS_NONE;
      beat.key_byte   = '0;
      beat.key_length = '0;
      beat.is_last    = 1'b1;
      answer_q.push_back(beat);
    end else begin
      for (int k = 0; k < key_len; k++) begin
        beat.status     = STATUS_KEY;
        beat.key_byte   = key_mem[k];
        beat.key_length = key_len[KEY_LENGTH_W-1:0];
        beat.is_last    = (k == key_len - 1);
        answer_q.push_back(beat);
      end
    end
    key_found = 1'b0;
    conflict = 1'b0;
    key_len = 0;
    restart_run();
  endfunction

  // ------------------------------------------------------------------ checker

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_beat();
    answer_beat_t want;
    answer_beat_t got;
    got.status     = out_tdata[STATUS_W-1:0];
    got.key_byte   = out_tdata[KB_LSB +: KEY_BYTE_W];
    got.key_length = out_tdata[KL_LSB +: KEY_LENGTH_W];
    got.is_last    = out_tlast;
    if (answer_q.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, actual status %0d key_byte %0d %s %0d",
               $time, got.status, got.key_byte, "key_length", got.key_length);
      errors++;
      return;
    end
    want = answer_q.pop_front();
    beats_checked++;
    compare_field("status", want.status, got.status);
    compare_field("key_byte", want.key_byte, got.key_byte);
    compare_field("key_length", want.key_length, got.key_length);
    compare_field("last_result", want.is_last, got.is_last);
    compare_field("tdata pad", 0, out_tdata[OUT_TDATA_W-1:PAD_LSB]);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_beat();
  end

  // Output back-pressure changes on the falling edge.
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] rand_b58();
    int idx;
    idx = $urandom_range(57);
    return B58_CHARS[8*idx +: 8];
  endfunction

  function automatic logic [7:0] rand_other();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_b58(b));
    return b;
  endfunction

  // The first nvalid bytes are base58 characters, the rest are arbitrary.
  function automatic logic [63:0] make_prefix_word(int nvalid);
    logic [63:0] w;
    for (int i = 0; i < 8; i++) begin
      w[8*i +: 8] = (i < nvalid) ? rand_b58() : 8'($urandom_range(255));
    end
    return w;
  endfunction

  function automatic void spoil(int idx);
    logic [7:0] c;
    do c = rand_b58(); while (c == run_buf[idx]);
    run_buf[idx] = c;
  endfunction

  function automatic void make_run(int len, bit pfx_good);
    int plen;
    int lim;
    plen = eff_pfx_len();
    run_buf.delete();
    for (int i = 0; i < len; i++) begin
      run_buf.push_back((i < plen) ? pfx_char(i) : rand_b58());
    end
    lim = (plen < len) ? plen : len;
    if (!pfx_good && lim > 0) spoil($urandom_range(lim - 1));
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    predict_answer(b, last);
    bytes_sent++;
    if (last) buffers_sent++;
  endtask

  task automatic send_run(bit last_at_end);
    foreach (run_buf[i]) send_byte(run_buf[i], last_at_end && (i == run_buf.size() - 1));
  endtask

  task automatic send_sep(bit last);
    send_byte(rand_other(), last);
  endtask

  // Stops input, waits for every predicted result, then lets the block settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [PREFIX_WORD_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PREFIX_LENGTH:      pfx_len_reg = val[PREFIX_LENGTH_W-1:0];
      REG_PREFIX_FIRST_EIGHT: pfx_lo_reg = val;
      REG_PREFIX_LAST_EIGHT:  pfx_hi_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_prefix(int len, logic [63:0] lo, logic [63:0] hi);
    logic [63:0] w;
    drain();
    // Bits above the length field carry junk; only the low bits count.
    w = {$urandom, $urandom};
    w[PREFIX_LENGTH_W-1:0] = len[PREFIX_LENGTH_W-1:0];
    write_reg(REG_PREFIX_LENGTH, w);
    write_reg(REG_PREFIX_FIRST_EIGHT, lo);
    write_reg(REG_PREFIX_LAST_EIGHT, hi);
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_empty_prefix();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // With no prefix configured even a well-formed run yields no key.
    make_run(KEY_MIN, 1'b1);
    send_run(1'b1);
  endtask

  task automatic test_length_limits();
    set_prefix(3, make_prefix_word(3), make_prefix_word(0));
    send_idle_pct = 86;
    recv_stall_pct = 0;
    // An overlong run is dropped; a run of the longest length, still open at
    // the last byte, becomes the key.
    make_run(KEY_MAX + 1, 1'b1);
    send_run(1'b0);
    send_sep(1'b0);
    make_run(KEY_MAX, 1'b1);
    send_run(1'b1);
  endtask

  task automatic test_conflict();
    send_idle_pct = 0;
    recv_stall_pct = 86;
    // A second key of the same length that differs after the prefix.
    make_run(KEY_MIN, 1'b1);
    saved_run = run_buf;
    send_run(1'b0);
    send_byte(8'h00, 1'b0);
    run_buf = saved_run;
    spoil(KEY_MIN / 2);
    send_run(1'b1);
    // A longer copy of the stored key differs from it.
    make_run(KEY_MIN, 1'b1);
    saved_run = run_buf;
    send_run(1'b0);
    send_byte(8'h00, 1'b0);
    run_buf = saved_run;
    run_buf.push_back(rand_b58());
    send_run(1'b1);
  endtask

  task automatic test_prefix_lengths();
    // A length above the maximum acts as the full sixteen-byte prefix.
    set_prefix(31, make_prefix_word(8), make_prefix_word(8));
    send_idle_pct = 22;
    recv_stall_pct = 22;
    // A mismatch in the upper prefix word rejects the run; the next is the key.
    make_run(KEY_MIN, 1'b1);
    spoil(12);
    send_run(1'b0);
    send_sep(1'b0);
    make_run(KEY_MIN, 1'b1);
    send_run(1'b1);
  endtask

  initial begin
    foreach (key_mem[i]) key_mem[i] = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_prefix();
    test_length_limits();
    test_conflict();
    test_prefix_lengths();

    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    $display("Scanned %0d bytes in %0d buffers and checked %0d result transactions,",
             bytes_sent, buffers_sent, beats_checked);
    $display("with empty, short and full prefixes, length limits and conflicts under load.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Timeout: %0d result transactions still expected.", answer_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
